// ===== src/page_replacement_engine_top_macros.svh =====
// Assertion macros for the page replacement engine.
// Depends on: a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define PRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define PRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pre_pkg.sv =====
// Shared constants for the page replacement engine.
// No dependencies; used by page_replacement_engine_top.
`timescale 1ns / 1ps
`default_nettype none

package pre_pkg;

    // Default sizing
    localparam int DEF_PAGES      = 256;
    localparam int DEF_MAX_FRAMES = 16;

    // Fixed field widths
    localparam int PAGE_W     = 8;
    localparam int FRAME_W    = 4;
    localparam int CFG_DATA_W = 5;
    localparam int COUNT_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int TOTAL_W    = 32;

    // Configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    // Replacement policy codes; the spare code acts as FIFO
    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_LRU  = 2'd1;
    localparam logic [1:0] POLICY_MFU  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [1:0]            RST_POLICY = POLICY_FIFO;
    localparam logic [CFG_DATA_W-1:0] RST_FRAMES = 5'd16;

endpackage

`default_nettype wire

// ===== src/page_replacement_engine_top.sv =====
// Page replacement engine: one page access in, one fault/frame/eviction result out.
// Throughput: one transaction at a time; the LRU/MFU scan walks the frame table RAM
// one entry a cycle and, for MFU, the page table RAM through its single read port.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes every entry of
// the page table while in_stall stays high. Configuration writes are taken throughout.
// Depends on: pre_pkg, pre_ram, page_replacement_engine_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "page_replacement_engine_top_macros.svh"

module page_replacement_engine_top #(
    parameter int PAGES      = pre_pkg::DEF_PAGES,
    parameter int MAX_FRAMES = pre_pkg::DEF_MAX_FRAMES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // access channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pre_pkg::PAGE_W-1:0]      page,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            fault,
    output logic [pre_pkg::FRAME_W-1:0]     frame,
    output logic                            evicted_valid,
    output logic [pre_pkg::PAGE_W-1:0]      evicted_page,
    output logic [pre_pkg::TOTAL_W-1:0]     fault_total,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [pre_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int PW   = $clog2(PAGES);                            // page address bits
    localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1; // frame index bits
    localparam int CW   = $clog2(MAX_FRAMES + 1);                   // frame count bits
    localparam int NW   = CW + pre_pkg::CFG_DATA_W;                 // frame count compare
    localparam int CNTW = pre_pkg::COUNT_W;
    localparam int STW  = pre_pkg::STAMP_W;
    localparam int PGW  = pre_pkg::PAGE_W;
    localparam int FRW  = pre_pkg::FRAME_W;

    // Page table entry: resident bit, frame, use count
    typedef struct packed {
        logic            resident;
        logic [FW-1:0]   frm;
        logic [CNTW-1:0] cnt;
    } page_entry_t;

    // Frame table entry: owning page, last use stamp
    typedef struct packed {
        logic [PW-1:0]   owner;
        logic [STW-1:0]  last_use;
    } frame_entry_t;

    localparam int PEW = $bits(page_entry_t);
    localparam int FEW = $bits(frame_entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,   // zero the page table after reset
        ST_IDLE,    // wait for an access
        ST_LOOK,    // page table entry arrives; hit, fill or pick a policy
        ST_SCAN,    // walk frames for the LRU or MFU victim
        ST_EVRD,    // read the victim frame's owner
        ST_EVICT,   // drop the old owner from the page table
        ST_COMMIT,  // install the page and stamp its frame
        ST_DONE     // hand the result to the output register
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                   state_reg,       state_next;
    logic [1:0]               policy_reg,      policy_next;
    logic [pre_pkg::CFG_DATA_W-1:0] frames_cfg_reg, frames_cfg_next;
    logic [PW-1:0]            clr_idx_reg,     clr_idx_next;
    logic [PW-1:0]            page_reg,        page_next;
    logic [STW-1:0]           stamp_reg,       stamp_next;
    logic [CW-1:0]            filled_reg,      filled_next;
    logic [FW-1:0]            fifo_reg,        fifo_next;
    logic [pre_pkg::TOTAL_W-1:0] fault_cnt_reg, fault_cnt_next;
    logic [FW-1:0]            victim_reg,      victim_next;
    logic                     evict_reg,       evict_next;
    logic [PGW-1:0]           ev_page_reg,     ev_page_next;
    // scan pipeline
    logic [CW-1:0]            scan_issue_reg,  scan_issue_next;
    logic                     s1_valid_reg,    s1_valid_next;
    logic [FW-1:0]            s1_idx_reg,      s1_idx_next;
    logic                     s2_valid_reg,    s2_valid_next;
    logic [FW-1:0]            s2_idx_reg,      s2_idx_next;
    logic                     best_have_reg,   best_have_next;
    logic [STW-1:0]           best_val_reg,    best_val_next;
    logic [FW-1:0]            best_idx_reg,    best_idx_next;
    // finished result, waiting for the output register
    logic                     res_fault_reg,   res_fault_next;
    logic [FRW-1:0]           res_frame_reg,   res_frame_next;
    logic                     res_ev_valid_reg, res_ev_valid_next;
    logic [PGW-1:0]           res_ev_page_reg, res_ev_page_next;
    logic [pre_pkg::TOTAL_W-1:0] res_total_reg, res_total_next;
    // output register
    logic                     out_valid_reg,   out_valid_next;
    logic                     out_fault_reg,   out_fault_next;
    logic [FRW-1:0]           out_frame_reg,   out_frame_next;
    logic                     out_ev_valid_reg, out_ev_valid_next;
    logic [PGW-1:0]           out_ev_page_reg, out_ev_page_next;
    logic [pre_pkg::TOTAL_W-1:0] out_total_reg, out_total_next;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic                     pg_we;
    logic [PW-1:0]            pg_waddr, pg_raddr;
    logic [PEW-1:0]           pg_wdata, pg_rdata;
    logic                     fr_we;
    logic [FW-1:0]            fr_waddr, fr_raddr;
    logic [FEW-1:0]           fr_wdata, fr_rdata;

    page_entry_t              pe_rd;
    frame_entry_t             fe_rd;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic [PW+PGW-1:0]        page_ext;
    logic [PW-1:0]            page_addr_in;
    logic                     page_in_range;
    logic [NW-1:0]            n_wide;
    logic [CW-1:0]            n_eff;
    logic [FW-1:0]            fifo_adj;
    logic [FW-1:0]            fifo_inc;
    logic [CNTW-1:0]          cnt_sat;
    logic [STW-1:0]           age;
    logic [FW+FRW-1:0]        hit_frame_w;
    logic [FW+FRW-1:0]        victim_frame_w;
    logic [PW+PGW-1:0]        old_page_w;
    logic                     cand_valid;
    logic [STW-1:0]           cand_val;
    logic [FW-1:0]            cand_idx;

    assign pe_rd = page_entry_t'(pg_rdata);
    assign fe_rd = frame_entry_t'(fr_rdata);

    // Zero-extend the page to the table's address width; pages at or above PAGES are rejected
    assign page_ext      = {{PW{1'b0}}, page};
    assign page_addr_in  = page_ext[PW-1:0];
    assign page_in_range = page_ext < (PW+PGW)'(PAGES);

    // Effective frame count: zero acts as one, anything above MAX_FRAMES is clamped
    always_comb
    begin
        if (frames_cfg_reg == '0)
        begin
            n_wide = NW'(1);
        end
        else if (NW'(frames_cfg_reg) > NW'(MAX_FRAMES))
        begin
            n_wide = NW'(MAX_FRAMES);
        end
        else
        begin
            n_wide = NW'(frames_cfg_reg);
        end
    end
    assign n_eff = n_wide[CW-1:0];

    // FIFO pointer restarts at frame 0 when the frame count has shrunk to or below it
    assign fifo_adj = (CW'(fifo_reg) >= n_eff) ? '0 : fifo_reg;
    assign fifo_inc = ((CW'(fifo_adj) + CW'(1)) >= n_eff) ? '0 : (fifo_adj + FW'(1));

    assign cnt_sat = (pe_rd.cnt != '1) ? (pe_rd.cnt + CNTW'(1)) : pe_rd.cnt;
    // Age is taken modulo 2^32, so stamp wrap does no harm
    assign age     = stamp_reg - fe_rd.last_use;

    assign hit_frame_w    = {{FRW{1'b0}}, pe_rd.frm};
    assign victim_frame_w = {{FRW{1'b0}}, victim_reg};
    assign old_page_w     = {{PGW{1'b0}}, fe_rd.owner};

    // LRU compares ages as frame data returns; MFU compares counts one stage later
    always_comb
    begin
        if (policy_reg == pre_pkg::POLICY_LRU)
        begin
            cand_valid = s1_valid_reg;
            cand_val   = age;
            cand_idx   = s1_idx_reg;
        end
        else
        begin
            cand_valid = s2_valid_reg;
            cand_val   = STW'(pe_rd.cnt);
            cand_idx   = s2_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        policy_next       = policy_reg;
        frames_cfg_next   = frames_cfg_reg;
        clr_idx_next      = clr_idx_reg;
        page_next         = page_reg;
        stamp_next        = stamp_reg;
        filled_next       = filled_reg;
        fifo_next         = fifo_reg;
        fault_cnt_next    = fault_cnt_reg;
        victim_next       = victim_reg;
        evict_next        = evict_reg;
        ev_page_next      = ev_page_reg;
        scan_issue_next   = scan_issue_reg;
        s1_valid_next     = 1'b0;
        s1_idx_next       = s1_idx_reg;
        s2_valid_next     = 1'b0;
        s2_idx_next       = s2_idx_reg;
        best_have_next    = best_have_reg;
        best_val_next     = best_val_reg;
        best_idx_next     = best_idx_reg;
        res_fault_next    = res_fault_reg;
        res_frame_next    = res_frame_reg;
        res_ev_valid_next = res_ev_valid_reg;
        res_ev_page_next  = res_ev_page_reg;
        res_total_next    = res_total_reg;
        out_valid_next    = out_valid_reg;
        out_fault_next    = out_fault_reg;
        out_frame_next    = out_frame_reg;
        out_ev_valid_next = out_ev_valid_reg;
        out_ev_page_next  = out_ev_page_reg;
        out_total_next    = out_total_reg;

        pg_we    = 1'b0;
        pg_waddr = page_reg;
        pg_wdata = '0;
        pg_raddr = page_addr_in;
        fr_we    = 1'b0;
        fr_waddr = victim_reg;
        fr_wdata = '0;
        fr_raddr = scan_issue_reg[FW-1:0];

        // Configuration writes land whenever they arrive
        if (cfg_valid)
        begin
            case (cfg_index)
                pre_pkg::CFG_POLICY: policy_next     = cfg_data[1:0];
                pre_pkg::CFG_FRAMES: frames_cfg_next = cfg_data;
                default:             ;
            endcase
        end

        // Drop the output transaction once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                pg_we        = 1'b1;
                pg_waddr     = clr_idx_reg;
                pg_wdata     = '0;
                clr_idx_next = clr_idx_reg + PW'(1);
                if (clr_idx_reg == PW'(PAGES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    page_next = page_addr_in;
                    if (page_in_range)
                    begin
                        state_next = ST_LOOK;
                    end
                    else
                    begin
                        // out-of-range page: no state change, empty answer
                        res_fault_next    = 1'b0;
                        res_frame_next    = '0;
                        res_ev_valid_next = 1'b0;
                        res_ev_page_next  = '0;
                        res_total_next    = fault_cnt_reg;
                        state_next        = ST_DONE;
                    end
                end
            end

            ST_LOOK:
            begin
                if (pe_rd.resident)
                begin
                    // hit: bump the use count, stamp the frame
                    pg_we             = 1'b1;
                    pg_waddr          = page_reg;
                    pg_wdata          = {1'b1, pe_rd.frm, cnt_sat};
                    fr_we             = 1'b1;
                    fr_waddr          = pe_rd.frm;
                    fr_wdata          = {page_reg, stamp_reg};
                    stamp_next        = stamp_reg + STW'(1);
                    res_fault_next    = 1'b0;
                    res_frame_next    = hit_frame_w[FRW-1:0];
                    res_ev_valid_next = 1'b0;
                    res_ev_page_next  = '0;
                    res_total_next    = fault_cnt_reg;
                    state_next        = ST_DONE;
                end
                else
                begin
                    if (fault_cnt_reg != '1)
                    begin
                        fault_cnt_next = fault_cnt_reg + 32'd1;
                    end
                    if (filled_reg < n_eff)
                    begin
                        // a never-used frame remains
                        victim_next  = filled_reg[FW-1:0];
                        filled_next  = filled_reg + CW'(1);
                        evict_next   = 1'b0;
                        ev_page_next = '0;
                        state_next   = ST_COMMIT;
                    end
                    else
                    begin
                        case (policy_reg)
                            pre_pkg::POLICY_LRU, pre_pkg::POLICY_MFU:
                            begin
                                scan_issue_next = '0;
                                best_have_next  = 1'b0;
                                state_next      = ST_SCAN;
                            end
                            default:
                            begin
                                victim_next = fifo_adj;
                                fifo_next   = fifo_inc;
                                evict_next  = 1'b1;
                                state_next  = ST_EVRD;
                            end
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                // issue stage: read the next frame entry
                if (scan_issue_reg < n_eff)
                begin
                    fr_raddr        = scan_issue_reg[FW-1:0];
                    scan_issue_next = scan_issue_reg + CW'(1);
                    s1_valid_next   = 1'b1;
                    s1_idx_next     = scan_issue_reg[FW-1:0];
                end
                // frame data stage: fetch the owner's use count
                if (s1_valid_reg)
                begin
                    pg_raddr      = fe_rd.owner;
                    s2_valid_next = 1'b1;
                    s2_idx_next   = s1_idx_reg;
                end
                // keep the first strictly better candidate, so the lowest frame wins ties
                if (cand_valid && (!best_have_reg || (cand_val > best_val_reg)))
                begin
                    best_have_next = 1'b1;
                    best_val_next  = cand_val;
                    best_idx_next  = cand_idx;
                end
                if ((scan_issue_reg >= n_eff) && !s1_valid_reg && !s2_valid_reg)
                begin
                    victim_next = best_idx_reg;
                    evict_next  = 1'b1;
                    state_next  = ST_EVRD;
                end
            end

            ST_EVRD:
            begin
                fr_raddr   = victim_reg;
                state_next = ST_EVICT;
            end

            ST_EVICT:
            begin
                // old owner leaves: not resident, count cleared
                pg_we        = 1'b1;
                pg_waddr     = fe_rd.owner;
                pg_wdata     = '0;
                ev_page_next = old_page_w[PGW-1:0];
                state_next   = ST_COMMIT;
            end

            ST_COMMIT:
            begin
                pg_we             = 1'b1;
                pg_waddr          = page_reg;
                pg_wdata          = {1'b1, victim_reg, CNTW'(1)};
                fr_we             = 1'b1;
                fr_waddr          = victim_reg;
                fr_wdata          = {page_reg, stamp_reg};
                stamp_next        = stamp_reg + STW'(1);
                res_fault_next    = 1'b1;
                res_frame_next    = victim_frame_w[FRW-1:0];
                res_ev_valid_next = evict_reg;
                res_ev_page_next  = ev_page_reg;
                res_total_next    = fault_cnt_reg;
                state_next        = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_fault_next    = res_fault_reg;
                    out_frame_next    = res_frame_reg;
                    out_ev_valid_next = res_ev_valid_reg;
                    out_ev_page_next  = res_ev_page_reg;
                    out_total_next    = res_total_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            policy_reg       <= pre_pkg::RST_POLICY;
            frames_cfg_reg   <= pre_pkg::RST_FRAMES;
            clr_idx_reg      <= '0;
            page_reg         <= '0;
            stamp_reg        <= '0;
            filled_reg       <= '0;
            fifo_reg         <= '0;
            fault_cnt_reg    <= '0;
            victim_reg       <= '0;
            evict_reg        <= 1'b0;
            ev_page_reg      <= '0;
            scan_issue_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s1_idx_reg       <= '0;
            s2_valid_reg     <= 1'b0;
            s2_idx_reg       <= '0;
            best_have_reg    <= 1'b0;
            best_val_reg     <= '0;
            best_idx_reg     <= '0;
            res_fault_reg    <= 1'b0;
            res_frame_reg    <= '0;
            res_ev_valid_reg <= 1'b0;
            res_ev_page_reg  <= '0;
            res_total_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_fault_reg    <= 1'b0;
            out_frame_reg    <= '0;
            out_ev_valid_reg <= 1'b0;
            out_ev_page_reg  <= '0;
            out_total_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            policy_reg       <= policy_next;
            frames_cfg_reg   <= frames_cfg_next;
            clr_idx_reg      <= clr_idx_next;
            page_reg         <= page_next;
            stamp_reg        <= stamp_next;
            filled_reg       <= filled_next;
            fifo_reg         <= fifo_next;
            fault_cnt_reg    <= fault_cnt_next;
            victim_reg       <= victim_next;
            evict_reg        <= evict_next;
            ev_page_reg      <= ev_page_next;
            scan_issue_reg   <= scan_issue_next;
            s1_valid_reg     <= s1_valid_next;
            s1_idx_reg       <= s1_idx_next;
            s2_valid_reg     <= s2_valid_next;
            s2_idx_reg       <= s2_idx_next;
            best_have_reg    <= best_have_next;
            best_val_reg     <= best_val_next;
            best_idx_reg     <= best_idx_next;
            res_fault_reg    <= res_fault_next;
            res_frame_reg    <= res_frame_next;
            res_ev_valid_reg <= res_ev_valid_next;
            res_ev_page_reg  <= res_ev_page_next;
            res_total_reg    <= res_total_next;
            out_valid_reg    <= out_valid_next;
            out_fault_reg    <= out_fault_next;
            out_frame_reg    <= out_frame_next;
            out_ev_valid_reg <= out_ev_valid_next;
            out_ev_page_reg  <= out_ev_page_next;
            out_total_reg    <= out_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Memories: page table (resident, frame, count) and frame table (owner, stamp)
    // ------------------------------------------------------------------
    pre_ram #(
        .WIDTH (PEW),
        .DEPTH (PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    pre_ram #(
        .WIDTH (FEW),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign fault         = out_fault_reg;
    assign frame         = out_frame_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign fault_total   = out_total_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PRE_ASSERT_NOW(a_evict_needs_fault, out_valid_reg && out_ev_valid_reg, out_fault_reg,
        "eviction reported without a fault")
    `PRE_ASSERT_NEXT(a_fault_count_monotonic, 1'b1, fault_cnt_reg >= $past(fault_cnt_reg),
        "fault counter went backwards")
    `PRE_ASSERT_NOW(a_filled_bounded, 1'b1, filled_reg <= CW'(MAX_FRAMES),
        "more frames filled than exist")
    `PRE_ASSERT_NEXT(a_done_delivers, (state_reg == ST_DONE) && (!out_valid_reg || !out_stall),
        out_valid_reg && (state_reg == ST_IDLE), "finished result not delivered")

endmodule

`default_nettype wire

// ===== src/pre_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
